/* hw/rtl/uvsg_pkg.sv */
// ----------------------------------------------------------------------------
// uvsg_pkg
// Shared constants, types and helper functions of the UV sphere vertex
// generator.
// ----------------------------------------------------------------------------
package uvsg_pkg;

    localparam int MAX_DIVISIONS = 1024;
    localparam int ANGLE_BITS    = 16;
    localparam int TEX_BITS      = 16;

    localparam int CNT_W   = 11;
    localparam int RAD_W   = 16;
    localparam int POS_W   = 17;
    localparam int NRM_W   = 16;
    localparam int TEX_W   = 17;

    // Quotient width of the fraction dividers: the largest fraction is 2^bits.
    localparam int Q_W     = ((ANGLE_BITS > TEX_BITS) ? ANGLE_BITS : TEX_BITS) + 1;
    localparam int NUM_W   = Q_W + CNT_W;
    localparam int REM_W   = CNT_W + 1;
    localparam int LANES   = 4;

    localparam int CORDIC_STEPS = 30;
    localparam int XW           = 34;
    localparam int PH_W         = 32;
    localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;

    // Total register stages from an accepted start to the done strobe.
    localparam int LATENCY = Q_W + CORDIC_STEPS + 6;

    typedef enum logic [1:0] {
        REG_RADIUS  = 2'd0,
        REG_SECTORS = 2'd1,
        REG_STACKS  = 2'd2
    } reg_index_t;

    // Divider lanes.
    localparam int LANE_TEX_U = 0;
    localparam int LANE_TEX_V = 1;
    localparam int LANE_SECT  = 2;
    localparam int LANE_STACK = 3;

    typedef struct packed {
        logic             err;
        logic [TEX_W-1:0] tex_u;
        logic [TEX_W-1:0] tex_v;
    } side_t;

    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] r);
        logic [CNT_W-1:0] e;
        if (r == '0)
            e = CNT_W'(1);
        else if (r > CNT_W'(MAX_DIVISIONS))
            e = CNT_W'(MAX_DIVISIONS);
        else
            e = r;
        return e;
    endfunction

    // Dividend of round(num * 2^bits / den), rounding half up.
    function automatic logic [NUM_W-1:0] frac_num(input logic [CNT_W-1:0] num,
                                                  input logic [CNT_W-1:0] den,
                                                  input int bits);
        return (NUM_W'(num) << bits) + NUM_W'(den >> 1);
    endfunction

    // Arctangent of 2^-i in 2^-32 turn units.
    function automatic logic signed [XW-1:0] atan_turn(input int i);
        logic signed [XW-1:0] a;
        case (i)
            0:  a = 34'sd536870912;
            1:  a = 34'sd316933406;
            2:  a = 34'sd167458907;
            3:  a = 34'sd85004756;
            4:  a = 34'sd42667331;
            5:  a = 34'sd21354465;
            6:  a = 34'sd10679838;
            7:  a = 34'sd5340245;
            8:  a = 34'sd2670163;
            9:  a = 34'sd1335087;
            10: a = 34'sd667544;
            11: a = 34'sd333772;
            12: a = 34'sd166886;
            13: a = 34'sd83443;
            14: a = 34'sd41722;
            15: a = 34'sd20861;
            16: a = 34'sd10430;
            17: a = 34'sd5215;
            18: a = 34'sd2608;
            19: a = 34'sd1304;
            20: a = 34'sd652;
            21: a = 34'sd326;
            22: a = 34'sd163;
            23: a = 34'sd81;
            24: a = 34'sd41;
            25: a = 34'sd20;
            26: a = 34'sd10;
            27: a = 34'sd5;
            28: a = 34'sd3;
            29: a = 34'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

/* hw/rtl/uvsg_divider.sv */
// ----------------------------------------------------------------------------
// uvsg_divider
// Pipelined restoring divider, four lanes, one quotient bit per stage.
// ----------------------------------------------------------------------------
module uvsg_divider (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 valid_in,
    input  logic                                 err_in,
    input  logic [uvsg_pkg::NUM_W-1:0]           num_in [uvsg_pkg::LANES],
    input  logic [uvsg_pkg::CNT_W-1:0]           den_in [uvsg_pkg::LANES],
    output logic                                 valid_out,
    output logic                                 err_out,
    output logic [uvsg_pkg::Q_W-1:0]             quot_out [uvsg_pkg::LANES]
);
    import uvsg_pkg::*;

    logic             valid_reg [Q_W+1];
    logic             err_reg   [Q_W+1];
    logic [REM_W-1:0] rem_reg   [Q_W+1][LANES];
    logic [Q_W-1:0]   low_reg   [Q_W+1][LANES];
    logic [Q_W-1:0]   quot_reg  [Q_W+1][LANES];

    // Entry stage: the part of the dividend above the quotient bits is
    // already below the divisor.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else
            valid_reg[0] <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        err_reg[0] <= err_in;
        for (int l = 0; l < LANES; l++)
        begin
            rem_reg[0][l]  <= REM_W'(num_in[l][NUM_W-1:Q_W]);
            low_reg[0][l]  <= num_in[l][Q_W-1:0];
            quot_reg[0][l] <= '0;
        end
    end

    for (genvar k = 0; k < Q_W; k++)
    begin : g_stage
        logic [REM_W-1:0] rem_next [LANES];
        logic             bit_next [LANES];

        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                logic [REM_W-1:0] t;
                t = {rem_reg[k][l][REM_W-2:0], low_reg[k][l][Q_W-1]};
                bit_next[l] = (t >= REM_W'(den_in[l]));
                rem_next[l] = bit_next[l] ? t - REM_W'(den_in[l]) : t;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k+1] <= 1'b0;
            else
                valid_reg[k+1] <= valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            err_reg[k+1] <= err_reg[k];
            for (int l = 0; l < LANES; l++)
            begin
                rem_reg[k+1][l]  <= rem_next[l];
                low_reg[k+1][l]  <= {low_reg[k][l][Q_W-2:0], 1'b0};
                quot_reg[k+1][l] <= {quot_reg[k][l][Q_W-2:0], bit_next[l]};
            end
        end
    end

    assign valid_out = valid_reg[Q_W];
    assign err_out   = err_reg[Q_W];
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            quot_out[l] = quot_reg[Q_W][l];
    end

endmodule

/* hw/rtl/uvsg_cordic.sv */
// ----------------------------------------------------------------------------
// uvsg_cordic
// Two-lane pipelined rotation CORDIC giving cosine and sine in Q4.30.
// ----------------------------------------------------------------------------
module uvsg_cordic (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                valid_in,
    input  uvsg_pkg::side_t                     side_in,
    input  logic [uvsg_pkg::PH_W-1:0]           phase_in [2],
    output logic                                valid_out,
    output uvsg_pkg::side_t                     side_out,
    output logic signed [uvsg_pkg::XW-1:0]      cos_out [2],
    output logic signed [uvsg_pkg::XW-1:0]      sin_out [2]
);
    import uvsg_pkg::*;

    logic                 valid_reg [CORDIC_STEPS+1];
    side_t                side_reg  [CORDIC_STEPS+1];
    logic                 flip_reg  [CORDIC_STEPS+1][2];
    logic signed [XW-1:0] x_reg     [CORDIC_STEPS+1][2];
    logic signed [XW-1:0] y_reg     [CORDIC_STEPS+1][2];
    logic signed [XW-1:0] z_reg     [CORDIC_STEPS+1][2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else
            valid_reg[0] <= valid_in;
    end

    // A phase in the left half plane is turned by half a turn; the results
    // are negated at the end.
    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_in;
        for (int l = 0; l < 2; l++)
        begin
            logic [PH_W-1:0] p;
            p = phase_in[l];
            flip_reg[0][l] <= p[PH_W-1] ^ p[PH_W-2];
            x_reg[0][l]    <= CORDIC_GAIN;
            y_reg[0][l]    <= '0;
            z_reg[0][l]    <= XW'($signed({p[PH_W-1] ^ p[PH_W-2] ^ p[PH_W-1],
                                           p[PH_W-2:0]}));
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i+1] <= 1'b0;
            else
                valid_reg[i+1] <= valid_reg[i];
        end

        always_ff @(posedge clk)
        begin
            side_reg[i+1] <= side_reg[i];
            for (int l = 0; l < 2; l++)
            begin
                flip_reg[i+1][l] <= flip_reg[i][l];
                if (!z_reg[i][l][XW-1])
                begin
                    x_reg[i+1][l] <= x_reg[i][l] - (y_reg[i][l] >>> i);
                    y_reg[i+1][l] <= y_reg[i][l] + (x_reg[i][l] >>> i);
                    z_reg[i+1][l] <= z_reg[i][l] - atan_turn(i);
                end
                else
                begin
                    x_reg[i+1][l] <= x_reg[i][l] + (y_reg[i][l] >>> i);
                    y_reg[i+1][l] <= y_reg[i][l] - (x_reg[i][l] >>> i);
                    z_reg[i+1][l] <= z_reg[i][l] + atan_turn(i);
                end
            end
        end
    end

    assign valid_out = valid_reg[CORDIC_STEPS];
    assign side_out  = side_reg[CORDIC_STEPS];
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            cos_out[l] = flip_reg[CORDIC_STEPS][l] ? -x_reg[CORDIC_STEPS][l]
                                                   :  x_reg[CORDIC_STEPS][l];
            sin_out[l] = flip_reg[CORDIC_STEPS][l] ? -y_reg[CORDIC_STEPS][l]
                                                   :  y_reg[CORDIC_STEPS][l];
        end
    end

endmodule

/* hw/rtl/uvsg_output.sv */
// ----------------------------------------------------------------------------
// uvsg_output
// Unit vector products, radius scaling, rounding and saturation.
// ----------------------------------------------------------------------------
module uvsg_output (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                valid_in,
    input  uvsg_pkg::side_t                     side_in,
    input  logic signed [uvsg_pkg::XW-1:0]      cos_s,
    input  logic signed [uvsg_pkg::XW-1:0]      sin_s,
    input  logic signed [uvsg_pkg::XW-1:0]      cos_c,
    input  logic signed [uvsg_pkg::XW-1:0]      sin_c,
    input  logic [uvsg_pkg::RAD_W-1:0]          radius,
    output logic                                done,
    output logic signed [uvsg_pkg::POS_W-1:0]   pos_x,
    output logic signed [uvsg_pkg::POS_W-1:0]   pos_y,
    output logic signed [uvsg_pkg::POS_W-1:0]   pos_z,
    output logic signed [uvsg_pkg::NRM_W-1:0]   normal_x,
    output logic signed [uvsg_pkg::NRM_W-1:0]   normal_y,
    output logic signed [uvsg_pkg::NRM_W-1:0]   normal_z,
    output logic [uvsg_pkg::TEX_W-1:0]          tex_u,
    output logic [uvsg_pkg::TEX_W-1:0]          tex_v,
    output logic                                index_error
);
    import uvsg_pkg::*;

    localparam int PR_W  = 2 * 32;
    localparam int RP_W  = RAD_W + 1 + XW;

    logic                   valid_reg [3];
    side_t                  side_reg  [3];
    logic signed [PR_W-1:0] prod_reg  [2];
    logic signed [XW-1:0]   z1_reg;
    logic signed [XW-1:0]   vec_reg   [3];
    logic signed [RP_W-1:0] rp_reg    [3];
    logic signed [NRM_W-1:0] nrm_reg  [3];

    logic signed [31:0]     cs32;
    logic signed [31:0]     cc32;
    logic signed [31:0]     sc32;

    assign cs32 = cos_s[31:0];
    assign cc32 = cos_c[31:0];
    assign sc32 = sin_c[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
            valid_reg[1] <= 1'b0;
            valid_reg[2] <= 1'b0;
            done         <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= valid_in;
            valid_reg[1] <= valid_reg[0];
            valid_reg[2] <= valid_reg[1];
            done         <= valid_reg[2];
        end
    end

    // Stage one: products of the two angles.
    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_in;
        prod_reg[0] <= cs32 * cc32;
        prod_reg[1] <= cs32 * sc32;
        z1_reg      <= sin_s;
    end

    // Stage two: round the products back to Q30.
    always_ff @(posedge clk)
    begin
        side_reg[1] <= side_reg[0];
        vec_reg[0]  <= XW'((prod_reg[0] + PR_W'(64'sd1 <<< 29)) >>> 30);
        vec_reg[1]  <= XW'((prod_reg[1] + PR_W'(64'sd1 <<< 29)) >>> 30);
        vec_reg[2]  <= z1_reg;
    end

    // Stage three: scale by the radius and form the normals.
    always_ff @(posedge clk)
    begin
        side_reg[2] <= side_reg[1];
        for (int k = 0; k < 3; k++)
        begin
            logic signed [XW-1:0] n;
            rp_reg[k] <= $signed({1'b0, radius}) * vec_reg[k];
            n = (vec_reg[k] + XW'(1 <<< 15)) >>> 16;
            if (n > XW'(16384))
                nrm_reg[k] <= NRM_W'(16384);
            else if (n < -XW'(16384))
                nrm_reg[k] <= -NRM_W'(16384);
            else
                nrm_reg[k] <= NRM_W'(n);
        end
    end

    // Stage four: round and saturate the positions; an index error clears all.
    logic signed [POS_W-1:0] pos_next [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic signed [RP_W-1:0] p;
            p = (rp_reg[k] + RP_W'(64'sd1 <<< 29)) >>> 30;
            if (p > RP_W'(65535))
                pos_next[k] = POS_W'(65535);
            else if (p < -RP_W'(65535))
                pos_next[k] = -POS_W'(65535);
            else
                pos_next[k] = POS_W'(p);
        end
    end

    always_ff @(posedge clk)
    begin
        index_error <= side_reg[2].err;
        if (side_reg[2].err)
        begin
            pos_x    <= '0;
            pos_y    <= '0;
            pos_z    <= '0;
            normal_x <= '0;
            normal_y <= '0;
            normal_z <= '0;
            tex_u    <= '0;
            tex_v    <= '0;
        end
        else
        begin
            pos_x    <= pos_next[0];
            pos_y    <= pos_next[1];
            pos_z    <= pos_next[2];
            normal_x <= nrm_reg[0];
            normal_y <= nrm_reg[1];
            normal_z <= nrm_reg[2];
            tex_u    <= side_reg[2].tex_u;
            tex_v    <= side_reg[2].tex_v;
        end
    end

endmodule

/* hw/rtl/uv_sphere_vertex_generator.sv */
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator
// Position, unit normal and texture coordinates of one UV sphere grid point.
// ----------------------------------------------------------------------------
// Usage: present stack_row and sector_col with start high; the point is
// taken at a clock edge where start is high and busy is low. busy never
// rises, so a new grid point may be presented in every cycle.
// Each result appears on the output ports for exactly one cycle with done
// high, once the point has passed the register stages: one entry
// stage, seventeen divider stages, one CORDIC set-up stage, thirty CORDIC
// rotations and four stages of products, scaling and saturation. The
// throughput is one vertex per cycle, set by the fully pipelined divider
// and CORDIC. The receiver must take every result as it passes; there is
// no back-pressure on the output side.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// writes the radius, sector count and stack count. cfg_ready is always high.
// Registers are to be changed only when no vertex is in flight.
// Reset clears the pipeline valid bits and loads radius 1.0, 36 sectors
// and 18 stacks; results stop at once.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [uvsg_pkg::CNT_W-1:0]          stack_row,
    input  logic [uvsg_pkg::CNT_W-1:0]          sector_col,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [uvsg_pkg::RAD_W-1:0]          cfg_data,
    output logic                                done,
    output logic signed [uvsg_pkg::POS_W-1:0]   pos_x,
    output logic signed [uvsg_pkg::POS_W-1:0]   pos_y,
    output logic signed [uvsg_pkg::POS_W-1:0]   pos_z,
    output logic signed [uvsg_pkg::NRM_W-1:0]   normal_x,
    output logic signed [uvsg_pkg::NRM_W-1:0]   normal_y,
    output logic signed [uvsg_pkg::NRM_W-1:0]   normal_z,
    output logic [uvsg_pkg::TEX_W-1:0]          tex_u,
    output logic [uvsg_pkg::TEX_W-1:0]          tex_v,
    output logic                                index_error
);
    import uvsg_pkg::*;

    // Configuration registers.
    logic [RAD_W-1:0] radius_reg;
    logic [CNT_W-1:0] sectors_reg;
    logic [CNT_W-1:0] stacks_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= RAD_W'(256);
            sectors_reg <= CNT_W'(36);
            stacks_reg  <= CNT_W'(18);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_index_t'(cfg_index))
                REG_RADIUS:  radius_reg  <= cfg_data;
                REG_SECTORS: sectors_reg <= cfg_data[CNT_W-1:0];
                REG_STACKS:  stacks_reg  <= cfg_data[CNT_W-1:0];
                default:     ;
            endcase
        end
    end

    // Effective counts: zero acts as one, and counts are capped.
    logic [CNT_W-1:0] sectors;
    logic [CNT_W-1:0] stacks;
    logic             accept;
    logic             range_err;

    assign sectors   = eff_count(sectors_reg);
    assign stacks    = eff_count(stacks_reg);
    assign accept    = start && !busy;
    assign range_err = (stack_row > stacks) || (sector_col > sectors);

    // The four fractions: both texture coordinates and both angle phases.
    logic [NUM_W-1:0] div_num [LANES];
    logic [CNT_W-1:0] div_den [LANES];

    always_comb
    begin
        div_num[LANE_TEX_U] = frac_num(sector_col, sectors, TEX_BITS);
        div_den[LANE_TEX_U] = sectors;
        div_num[LANE_TEX_V] = frac_num(stack_row, stacks, TEX_BITS);
        div_den[LANE_TEX_V] = stacks;
        div_num[LANE_SECT]  = frac_num(sector_col, sectors, ANGLE_BITS);
        div_den[LANE_SECT]  = sectors;
        div_num[LANE_STACK] = frac_num(stack_row, stacks, ANGLE_BITS - 1);
        div_den[LANE_STACK] = stacks;
    end

    logic           div_valid;
    logic           div_err;
    logic [Q_W-1:0] div_quot [LANES];

    uvsg_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (accept),
        .err_in    (range_err),
        .num_in    (div_num),
        .den_in    (div_den),
        .valid_out (div_valid),
        .err_out   (div_err),
        .quot_out  (div_quot)
    );

    // The sector angle is the fraction of a full turn; the stack angle is a
    // quarter turn less half a turn times v. Both are widened to 32 bits.
    logic [ANGLE_BITS-1:0] sect_ph;
    logic [ANGLE_BITS-1:0] stack_ph;
    logic [PH_W-1:0]       phase [2];
    side_t                 side;

    assign sect_ph  = div_quot[LANE_SECT][ANGLE_BITS-1:0];
    assign stack_ph = ANGLE_BITS'(1 << (ANGLE_BITS - 2))
                    - div_quot[LANE_STACK][ANGLE_BITS-1:0];

    always_comb
    begin
        phase[0]   = {stack_ph, {(PH_W - ANGLE_BITS){1'b0}}};
        phase[1]   = {sect_ph,  {(PH_W - ANGLE_BITS){1'b0}}};
        side.err   = div_err;
        side.tex_u = div_quot[LANE_TEX_U][TEX_W-1:0];
        side.tex_v = div_quot[LANE_TEX_V][TEX_W-1:0];
    end

    logic                 cor_valid;
    side_t                cor_side;
    logic signed [XW-1:0] cor_cos [2];
    logic signed [XW-1:0] cor_sin [2];

    uvsg_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (div_valid),
        .side_in   (side),
        .phase_in  (phase),
        .valid_out (cor_valid),
        .side_out  (cor_side),
        .cos_out   (cor_cos),
        .sin_out   (cor_sin)
    );

    uvsg_output u_output (
        .clk         (clk),
        .rst_n       (rst_n),
        .valid_in    (cor_valid),
        .side_in     (cor_side),
        .cos_s       (cor_cos[0]),
        .sin_s       (cor_sin[0]),
        .cos_c       (cor_cos[1]),
        .sin_c       (cor_sin[1]),
        .radius      (radius_reg),
        .done        (done),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .normal_x    (normal_x),
        .normal_y    (normal_y),
        .normal_z    (normal_z),
        .tex_u       (tex_u),
        .tex_v       (tex_v),
        .index_error (index_error)
    );

    // Every accepted point comes out after the fixed pipeline latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("accepted point did not produce a result in time");

    // An index error result carries nothing but the flag.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && index_error) |-> (pos_x == '0 && pos_y == '0 && pos_z == '0 &&
                                   normal_x == '0 && normal_y == '0 &&
                                   normal_z == '0 && tex_u == '0 && tex_v == '0))
        else $error("index error result with non-zero fields");

    // Normals stay within the unit range after saturation.
    a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (normal_x <= 16'sd16384 && normal_x >= -16'sd16384 &&
                  normal_y <= 16'sd16384 && normal_y >= -16'sd16384 &&
                  normal_z <= 16'sd16384 && normal_z >= -16'sd16384))
        else $error("normal component out of range");

endmodule
